@@ sv/cpu_6502_instruction_execute_assert.svh @@
// Assertion macros for the 6502 execute block
`ifndef CPU_6502_INSTRUCTION_EXECUTE_ASSERT_SVH
`define CPU_6502_INSTRUCTION_EXECUTE_ASSERT_SVH

// Check a condition on every clock edge outside reset
`define C6X_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that pre implies post in the next cycle, outside reset
`define C6X_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/c6x_pkg.sv @@
package c6x_pkg;

  localparam logic [7:0] SP_RESET = 8'hFD;
  localparam logic [7:0] P_RESET  = 8'h24;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_MEM   = 2'd1;
  localparam logic [1:0] KIND_STACK = 2'd2;

  typedef enum logic [5:0] {
    F_ADC = 6'd0,  F_AND = 6'd1,  F_ASL = 6'd2,  F_BCC = 6'd3,  F_BCS = 6'd4,
    F_BEQ = 6'd5,  F_BIT = 6'd6,  F_BMI = 6'd7,  F_BNE = 6'd8,  F_BPL = 6'd9,
    F_BRK = 6'd10, F_BVC = 6'd11, F_BVS = 6'd12, F_CLC = 6'd13, F_CLD = 6'd14,
    F_CLI = 6'd15, F_CLV = 6'd16, F_CMP = 6'd17, F_CPX = 6'd18, F_CPY = 6'd19,
    F_DEC = 6'd20, F_DEX = 6'd21, F_DEY = 6'd22, F_EOR = 6'd23, F_INC = 6'd24,
    F_INX = 6'd25, F_INY = 6'd26, F_JMP = 6'd27, F_JSR = 6'd28, F_LDA = 6'd29,
    F_LDX = 6'd30, F_LDY = 6'd31, F_LSR = 6'd32, F_NOP = 6'd33, F_ORA = 6'd34,
    F_PHA = 6'd35, F_PHP = 6'd36, F_PLA = 6'd37, F_PLP = 6'd38, F_ROL = 6'd39,
    F_ROR = 6'd40, F_RTI = 6'd41, F_RTS = 6'd42, F_SBC = 6'd43, F_SEC = 6'd44,
    F_SED = 6'd45, F_SEI = 6'd46, F_STA = 6'd47, F_STX = 6'd48, F_STY = 6'd49,
    F_TAX = 6'd50, F_TAY = 6'd51, F_TSX = 6'd52, F_TXA = 6'd53, F_TXS = 6'd54,
    F_TYA = 6'd55
  } func_t;

  typedef struct packed {
    logic [5:0]  func;
    logic [7:0]  operand;
    logic [15:0] pulled_word;
    logic [15:0] vector_word;
    logic [15:0] effective_addr;
    logic signed [7:0] rel_offset;
    logic        accumulator_mode;
    logic        page_crossed;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        last;
    logic [15:0] new_pc;
    logic [7:0]  new_a;
    logic [7:0]  new_x;
    logic [7:0]  new_y;
    logic [7:0]  new_sp;
    logic [7:0]  new_flags;
    logic [1:0]  extra_cycles;
  } out_item_t;

endpackage

@@ sv/cpu_6502_instruction_execute.sv @@
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_item_t (one decoded operation)
// out     | output    | out_valid/out_stall| out_item_t (writes, then registers)
// Each operation is executed as it is accepted; results come from a three-deep
// result buffer, so one operation gives one beat except BRK (three) and JSR (two).
// Sustained rate is one single-beat operation per cycle while out_stall is low, set by the result buffer drain.
// Reset (synchronous, rst high) sets A, X, Y, PC to zero, SP to FD, P to 24.
// Input is stalled while the buffer holds results that have not drained.
`include "cpu_6502_instruction_execute_assert.svh"
module cpu_6502_instruction_execute
  import c6x_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [7:0]  a, x, y, sp, p;
  logic [15:0] pc;

  // pending result beats: slot 0 is on the output
  out_item_t  buf0, buf1, buf2;
  logic [1:0] cnt;

  logic       take, pop;
  logic [7:0] a_n, x_n, y_n, sp_n, p_n;
  logic [15:0] pc_n;
  logic [1:0] nw, extra;
  logic [1:0] wk [3];
  logic [15:0] wa [3];
  logic [7:0] wd [3];

  logic [7:0]  m, v, r, zr;
  logic [8:0]  sum;
  logic        setzn, taken;
  logic [15:0] ret, tgt;
  out_item_t   fin;
  out_item_t   b0, b1, b2;

  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && !out_stall;
  // accept when the buffer is empty or empties in this cycle
  assign in_stall  = (cnt > 2'd1) || (cnt == 2'd1 && out_stall);
  assign take      = in_valid && !in_stall;
  assign out_data  = buf0;

  // execute one operation
  always_comb begin
    a_n = a; x_n = x; y_n = y; sp_n = sp; p_n = p; pc_n = pc;
    nw = 2'd0; extra = 2'd0; setzn = 1'b0; zr = 8'h00;
    for (int i = 0; i < 3; i++) begin
      wk[i] = KIND_NONE; wa[i] = 16'h0000; wd[i] = 8'h00;
    end
    m = in_data.operand;
    v = in_data.accumulator_mode ? a : m;
    r = 8'h00; sum = 9'h000; taken = 1'b0;
    ret = 16'h0000;
    tgt = pc + {{8{in_data.rel_offset[7]}}, in_data.rel_offset};
    case (in_data.func)
      F_ADC, F_SBC: begin
        if (in_data.func == F_SBC) m = ~in_data.operand;
        sum = {1'b0, a} + {1'b0, m} + {8'h00, p[0]};
        p_n[0] = sum[8];
        p_n[6] = ~(a[7] ^ m[7]) & (a[7] ^ sum[7]);
        a_n = sum[7:0]; zr = sum[7:0]; setzn = 1'b1;
        extra = {1'b0, in_data.page_crossed};
      end
      F_AND, F_EOR, F_ORA, F_LDA: begin
        case (in_data.func)
          F_AND:   a_n = a & m;
          F_EOR:   a_n = a ^ m;
          F_ORA:   a_n = a | m;
          default: a_n = m;
        endcase
        zr = a_n; setzn = 1'b1; extra = {1'b0, in_data.page_crossed};
      end
      F_ASL, F_LSR, F_ROL, F_ROR: begin
        case (in_data.func)
          F_ASL:   begin r = {v[6:0], 1'b0};  p_n[0] = v[7]; end
          F_LSR:   begin r = {1'b0, v[7:1]};  p_n[0] = v[0]; end
          F_ROL:   begin r = {v[6:0], p[0]};  p_n[0] = v[7]; end
          default: begin r = {p[0], v[7:1]};  p_n[0] = v[0]; end
        endcase
        zr = r; setzn = 1'b1;
        if (in_data.accumulator_mode) a_n = r;
        else begin
          nw = 2'd1; wk[0] = KIND_MEM; wa[0] = in_data.effective_addr; wd[0] = r;
        end
      end
      F_BCC, F_BCS, F_BEQ, F_BMI, F_BNE, F_BPL, F_BVC, F_BVS: begin
        case (in_data.func)
          F_BCC:   taken = !p[0];
          F_BCS:   taken = p[0];
          F_BEQ:   taken = p[1];
          F_BMI:   taken = p[7];
          F_BNE:   taken = !p[1];
          F_BPL:   taken = !p[7];
          F_BVC:   taken = !p[6];
          default: taken = p[6];
        endcase
        if (taken) begin
          pc_n = tgt;
          extra = (tgt[15:8] != pc[15:8]) ? 2'd2 : 2'd1;
        end
      end
      F_BIT: begin
        p_n[1] = (a & m) == 8'h00;
        p_n[7:6] = m[7:6];
      end
      F_BRK: begin
        ret = pc + 16'd1;
        nw = 2'd3;
        wk[0] = KIND_STACK; wa[0] = {8'h01, sp};          wd[0] = ret[15:8];
        wk[1] = KIND_STACK; wa[1] = {8'h01, sp - 8'd1};   wd[1] = ret[7:0];
        wk[2] = KIND_STACK; wa[2] = {8'h01, sp - 8'd2};   wd[2] = p | 8'h10;
        sp_n = sp - 8'd3; p_n[2] = 1'b1; pc_n = in_data.vector_word;
      end
      F_CLC: p_n[0] = 1'b0;
      F_CLD: p_n[3] = 1'b0;
      F_CLI: p_n[2] = 1'b0;
      F_CLV: p_n[6] = 1'b0;
      F_SEC: p_n[0] = 1'b1;
      F_SED: p_n[3] = 1'b1;
      F_SEI: p_n[2] = 1'b1;
      F_CMP, F_CPX, F_CPY: begin
        case (in_data.func)
          F_CMP:   r = a;
          F_CPX:   r = x;
          default: r = y;
        endcase
        p_n[0] = r >= m; zr = r - m; setzn = 1'b1;
        if (in_data.func == F_CMP) extra = {1'b0, in_data.page_crossed};
      end
      F_DEC, F_INC: begin
        r = (in_data.func == F_DEC) ? m - 8'd1 : m + 8'd1;
        zr = r; setzn = 1'b1;
        nw = 2'd1; wk[0] = KIND_MEM; wa[0] = in_data.effective_addr; wd[0] = r;
      end
      F_DEX: begin x_n = x - 8'd1; zr = x_n; setzn = 1'b1; end
      F_DEY: begin y_n = y - 8'd1; zr = y_n; setzn = 1'b1; end
      F_INX: begin x_n = x + 8'd1; zr = x_n; setzn = 1'b1; end
      F_INY: begin y_n = y + 8'd1; zr = y_n; setzn = 1'b1; end
      F_JMP: pc_n = in_data.effective_addr;
      F_JSR: begin
        ret = pc - 16'd1;
        nw = 2'd2;
        wk[0] = KIND_STACK; wa[0] = {8'h01, sp};        wd[0] = ret[15:8];
        wk[1] = KIND_STACK; wa[1] = {8'h01, sp - 8'd1}; wd[1] = ret[7:0];
        sp_n = sp - 8'd2; pc_n = in_data.effective_addr;
      end
      F_LDX: begin x_n = m; zr = m; setzn = 1'b1; extra = {1'b0, in_data.page_crossed}; end
      F_LDY: begin y_n = m; zr = m; setzn = 1'b1; extra = {1'b0, in_data.page_crossed}; end
      F_PHA: begin
        nw = 2'd1; wk[0] = KIND_STACK; wa[0] = {8'h01, sp}; wd[0] = a; sp_n = sp - 8'd1;
      end
      F_PHP: begin
        nw = 2'd1; wk[0] = KIND_STACK; wa[0] = {8'h01, sp}; wd[0] = p | 8'h10;
        sp_n = sp - 8'd1;
      end
      F_PLA: begin sp_n = sp + 8'd1; a_n = m; zr = m; setzn = 1'b1; end
      F_PLP: begin sp_n = sp + 8'd1; p_n = m | 8'h20; end
      F_RTI: begin sp_n = sp + 8'd3; p_n = m | 8'h20; pc_n = in_data.pulled_word; end
      F_RTS: begin sp_n = sp + 8'd2; pc_n = in_data.pulled_word + 16'd1; end
      F_STA: begin nw = 2'd1; wk[0] = KIND_MEM; wa[0] = in_data.effective_addr; wd[0] = a; end
      F_STX: begin nw = 2'd1; wk[0] = KIND_MEM; wa[0] = in_data.effective_addr; wd[0] = x; end
      F_STY: begin nw = 2'd1; wk[0] = KIND_MEM; wa[0] = in_data.effective_addr; wd[0] = y; end
      F_TAX: begin x_n = a; zr = a; setzn = 1'b1; end
      F_TAY: begin y_n = a; zr = a; setzn = 1'b1; end
      F_TSX: begin x_n = sp; zr = sp; setzn = 1'b1; end
      F_TXA: begin a_n = x; zr = x; setzn = 1'b1; end
      F_TXS: sp_n = x;
      F_TYA: begin a_n = y; zr = y; setzn = 1'b1; end
      default: ;
    endcase
    if (setzn) begin
      p_n[1] = (zr == 8'h00);
      p_n[7] = zr[7];
    end
  end

  // build the result beats: write beats, registers on the last one
  always_comb begin
    fin = '0;
    fin.last = 1'b1;
    fin.new_pc = pc_n; fin.new_a = a_n; fin.new_x = x_n; fin.new_y = y_n;
    fin.new_sp = sp_n; fin.new_flags = p_n; fin.extra_cycles = extra;
    b0 = '0; b1 = '0; b2 = '0;
    case (nw)
      2'd3: begin
        b0.kind = wk[0]; b0.write_addr = wa[0]; b0.write_data = wd[0];
        b1.kind = wk[1]; b1.write_addr = wa[1]; b1.write_data = wd[1];
        b2 = fin; b2.kind = wk[2]; b2.write_addr = wa[2]; b2.write_data = wd[2];
      end
      2'd2: begin
        b0.kind = wk[0]; b0.write_addr = wa[0]; b0.write_data = wd[0];
        b1 = fin; b1.kind = wk[1]; b1.write_addr = wa[1]; b1.write_data = wd[1];
      end
      default: begin
        b0 = fin; b0.kind = wk[0]; b0.write_addr = wa[0]; b0.write_data = wd[0];
      end
    endcase
  end

  // architectural registers and the result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      a <= 8'h00; x <= 8'h00; y <= 8'h00; sp <= SP_RESET; p <= P_RESET; pc <= 16'h0000;
      cnt <= 2'd0;
    end else if (take) begin
      a <= a_n; x <= x_n; y <= y_n; sp <= sp_n; p <= p_n; pc <= pc_n;
      cnt <= (nw == 2'd0) ? 2'd1 : nw;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      buf0 <= b0; buf1 <= b1; buf2 <= b2;
    end else if (pop) begin
      buf0 <= buf1; buf1 <= buf2;
    end
  end

  `C6X_ASSERT(a_take_empty, !(take && cnt > 2'd1), "accepted with results pending")
  `C6X_ASSERT_NEXT(a_take_valid, take, out_valid, "no beat after accept")
  `C6X_ASSERT_NEXT(a_last_hold, out_valid && out_data.last && out_stall,
                   out_valid && out_data.last, "last beat lost")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
  import c6x_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  cpu_6502_instruction_execute u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  localparam logic [7:0] FLAG_C = 8'h01;
  localparam logic [7:0] FLAG_Z = 8'h02;
  localparam logic [7:0] FLAG_I = 8'h04;
  localparam logic [7:0] FLAG_D = 8'h08;
  localparam logic [7:0] FLAG_B = 8'h10;
  localparam logic [7:0] FLAG_U = 8'h20;
  localparam logic [7:0] FLAG_V = 8'h40;
  localparam logic [7:0] FLAG_N = 8'h80;
  localparam int CYCLE_LIMIT = 400000;

  // shadow CPU registers
  logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
  logic [15:0] cpu_pc;
  out_item_t   pending_beats[$];
  out_item_t   wr_beats[$];

  int mismatches = 0;
  int beats_seen = 0;
  int ops_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  bit hold_done = 1'b0;

  function automatic void set_nz(input logic [7:0] v);
    cpu_p[1] = (v == 8'h00);
    cpu_p[7] = v[7];
  endfunction

  function automatic void push_stack(input logic [7:0] v);
    out_item_t b;
    b = '0;
    b.kind = KIND_STACK;
    b.write_addr = {8'h01, cpu_sp};
    b.write_data = v;
    wr_beats.push_back(b);
    cpu_sp = cpu_sp - 8'd1;
  endfunction

  function automatic void mem_write(input logic [15:0] ad, input logic [7:0] v);
    out_item_t b;
    b = '0;
    b.kind = KIND_MEM;
    b.write_addr = ad;
    b.write_data = v;
    wr_beats.push_back(b);
  endfunction

  function automatic void add_to_a(input logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, cpu_a} + {1'b0, m} + {8'd0, cpu_p[0]};
    cpu_p[0] = sum[8];
    cpu_p[6] = (~(cpu_a[7] ^ m[7])) & (cpu_a[7] ^ sum[7]);
    cpu_a = sum[7:0];
    set_nz(cpu_a);
  endfunction

  function automatic void compare_reg(input logic [7:0] rg, input logic [7:0] m);
    cpu_p[0] = (rg >= m);
    set_nz(rg - m);
  endfunction

  function automatic logic [1:0] take_branch(input bit taken, input logic [7:0] rel);
    logic [15:0] old_pc;
    if (!taken) return 2'd0;
    old_pc = cpu_pc;
    cpu_pc = cpu_pc + {{8{rel[7]}}, rel};
    return (old_pc[15:8] != cpu_pc[15:8]) ? 2'd2 : 2'd1;
  endfunction

  // compute the beats one operation produces and queue them
  function automatic void predict_op(input in_item_t it);
    logic [7:0]  v, r, m;
    logic [15:0] ret;
    logic [1:0]  extra;
    out_item_t   fin;
    m = it.operand;
    extra = 2'd0;
    wr_beats.delete();
    case (it.func)
      F_ADC: begin add_to_a(m); extra = {1'b0, it.page_crossed}; end
      F_SBC: begin add_to_a(~m); extra = {1'b0, it.page_crossed}; end
      F_AND: begin cpu_a = cpu_a & m; set_nz(cpu_a); extra = {1'b0, it.page_crossed}; end
      F_EOR: begin cpu_a = cpu_a ^ m; set_nz(cpu_a); extra = {1'b0, it.page_crossed}; end
      F_ORA: begin cpu_a = cpu_a | m; set_nz(cpu_a); extra = {1'b0, it.page_crossed}; end
      F_ASL, F_LSR, F_ROL, F_ROR: begin
        v = it.accumulator_mode ? cpu_a : m;
        case (it.func)
          F_ASL: begin r = v << 1; cpu_p[0] = v[7]; end
          F_LSR: begin r = v >> 1; cpu_p[0] = v[0]; end
          F_ROL: begin r = {v[6:0], cpu_p[0]}; cpu_p[0] = v[7]; end
          default: begin r = {cpu_p[0], v[7:1]}; cpu_p[0] = v[0]; end
        endcase
        set_nz(r);
        if (it.accumulator_mode) cpu_a = r;
        else mem_write(it.effective_addr, r);
      end
      F_BCC: extra = take_branch(!cpu_p[0], it.rel_offset);
      F_BCS: extra = take_branch(cpu_p[0], it.rel_offset);
      F_BEQ: extra = take_branch(cpu_p[1], it.rel_offset);
      F_BMI: extra = take_branch(cpu_p[7], it.rel_offset);
      F_BNE: extra = take_branch(!cpu_p[1], it.rel_offset);
      F_BPL: extra = take_branch(!cpu_p[7], it.rel_offset);
      F_BVC: extra = take_branch(!cpu_p[6], it.rel_offset);
      F_BVS: extra = take_branch(cpu_p[6], it.rel_offset);
      F_BIT: begin
        cpu_p[1] = ((cpu_a & m) == 8'h00);
        cpu_p = (cpu_p & 8'h3F) | (m & 8'hC0);
      end
      F_BRK: begin
        ret = cpu_pc + 16'd1;
        push_stack(ret[15:8]);
        push_stack(ret[7:0]);
        push_stack(cpu_p | FLAG_B);
        cpu_p = cpu_p | FLAG_I;
        cpu_pc = it.vector_word;
      end
      F_CLC: cpu_p = cpu_p & ~FLAG_C;
      F_CLD: cpu_p = cpu_p & ~FLAG_D;
      F_CLI: cpu_p = cpu_p & ~FLAG_I;
      F_CLV: cpu_p = cpu_p & ~FLAG_V;
      F_SEC: cpu_p = cpu_p | FLAG_C;
      F_SED: cpu_p = cpu_p | FLAG_D;
      F_SEI: cpu_p = cpu_p | FLAG_I;
      F_CMP: begin compare_reg(cpu_a, m); extra = {1'b0, it.page_crossed}; end
      F_CPX: compare_reg(cpu_x, m);
      F_CPY: compare_reg(cpu_y, m);
      F_DEC: begin r = m - 8'd1; set_nz(r); mem_write(it.effective_addr, r); end
      F_INC: begin r = m + 8'd1; set_nz(r); mem_write(it.effective_addr, r); end
      F_DEX: begin cpu_x = cpu_x - 8'd1; set_nz(cpu_x); end
      F_DEY: begin cpu_y = cpu_y - 8'd1; set_nz(cpu_y); end
      F_INX: begin cpu_x = cpu_x + 8'd1; set_nz(cpu_x); end
      F_INY: begin cpu_y = cpu_y + 8'd1; set_nz(cpu_y); end
      F_JMP: cpu_pc = it.effective_addr;
      F_JSR: begin
        ret = cpu_pc - 16'd1;
        push_stack(ret[15:8]);
        push_stack(ret[7:0]);
        cpu_pc = it.effective_addr;
      end
      F_LDA: begin cpu_a = m; set_nz(m); extra = {1'b0, it.page_crossed}; end
      F_LDX: begin cpu_x = m; set_nz(m); extra = {1'b0, it.page_crossed}; end
      F_LDY: begin cpu_y = m; set_nz(m); extra = {1'b0, it.page_crossed}; end
      F_PHA: push_stack(cpu_a);
      F_PHP: push_stack(cpu_p | FLAG_B);
      F_PLA: begin cpu_sp = cpu_sp + 8'd1; cpu_a = m; set_nz(m); end
      F_PLP: begin cpu_sp = cpu_sp + 8'd1; cpu_p = m | FLAG_U; end
      F_RTI: begin
        cpu_sp = cpu_sp + 8'd3;
        cpu_p = m | FLAG_U;
        cpu_pc = it.pulled_word;
      end
      F_RTS: begin cpu_sp = cpu_sp + 8'd2; cpu_pc = it.pulled_word + 16'd1; end
      F_STA: mem_write(it.effective_addr, cpu_a);
      F_STX: mem_write(it.effective_addr, cpu_x);
      F_STY: mem_write(it.effective_addr, cpu_y);
      F_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
      F_TAY: begin cpu_y = cpu_a; set_nz(cpu_y); end
      F_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
      F_TXA: begin cpu_a = cpu_x; set_nz(cpu_a); end
      F_TXS: cpu_sp = cpu_x;
      F_TYA: begin cpu_a = cpu_y; set_nz(cpu_a); end
      default: ;
    endcase
    if (wr_beats.size() == 0) wr_beats.push_back('0);
    fin = wr_beats.pop_back();
    while (wr_beats.size() > 0) pending_beats.push_back(wr_beats.pop_front());
    fin.last = 1'b1;
    fin.new_pc = cpu_pc;
    fin.new_a = cpu_a;
    fin.new_x = cpu_x;
    fin.new_y = cpu_y;
    fin.new_sp = cpu_sp;
    fin.new_flags = cpu_p;
    fin.extra_cycles = extra;
    pending_beats.push_back(fin);
  endfunction

  function automatic in_item_t make_op(input logic [5:0] f, input logic [7:0] m,
                                       input logic [15:0] ea, input logic [7:0] rel,
                                       input bit accm, input bit pgx);
    in_item_t it;
    it = '0;
    it.func = f;
    it.operand = m;
    it.effective_addr = ea;
    it.rel_offset = rel;
    it.accumulator_mode = accm;
    it.page_crossed = pgx;
    it.pulled_word = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    it.vector_word = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    return it;
  endfunction

  function automatic in_item_t rand_op();
    in_item_t it;
    it = '0;
    it.func = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(56, 63))
                                           : 6'($urandom_range(0, 55));
    it.operand = 8'($urandom());
    it.pulled_word = 16'($urandom());
    it.vector_word = 16'($urandom());
    it.effective_addr = 16'($urandom());
    it.rel_offset = 8'($urandom());
    it.accumulator_mode = 1'($urandom());
    it.page_crossed = 1'($urandom());
    return it;
  endfunction

  // offer one beat and hold it until accepted
  task automatic send_op(input in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_op(it);
    ops_sent++;
  endtask

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else out_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    int stretch;
    forever begin
      @(posedge clk);
      if (!rst && ops_sent >= 40 && !hold_done) begin
        hold_done = 1'b1;
        hold_off <= 1'b1;
        for (stretch = 0; stretch < 60; stretch++) @(posedge clk);
        hold_off <= 1'b0;
      end
    end
  end

  // compare every accepted result beat with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        want = pending_beats.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d mismatch: expected %p got %p", beats_seen, want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // directed stimulus: known values after reset, extremes, every operation
  typedef struct {
    in_item_t  op;
    bit        check_regs;
    logic [7:0] a_exp, p_exp, sp_exp;
  } step_row_t;
  step_row_t steps[$];

  initial begin
    int i, ph, n;
    in_item_t it;
    steps.push_back('{make_op(F_NOP, 8'h00, 16'h0000, 8'h00, 0, 1), 1, 8'h00, 8'h24, 8'hFD});
    steps.push_back('{make_op(F_LDA, 8'h80, 16'hFFFF, 8'h00, 1, 1), 1, 8'h80, 8'hA4, 8'hFD});
    steps.push_back('{make_op(F_LDA, 8'h00, 16'h0000, 8'h00, 0, 0), 1, 8'h00, 8'h26, 8'hFD});
    steps.push_back('{make_op(F_SEC, 8'hFF, 16'h0000, 8'h00, 0, 1), 0, 0, 0, 0});
    steps.push_back('{make_op(F_ADC, 8'hFF, 16'h0000, 8'h00, 0, 1), 0, 0, 0, 0});
    steps.push_back('{make_op(F_ADC, 8'h7F, 16'h0000, 8'h00, 0, 0), 0, 0, 0, 0});
    steps.push_back('{make_op(F_SBC, 8'h80, 16'h0000, 8'h00, 0, 1), 0, 0, 0, 0});
    steps.push_back('{make_op(F_BIT, 8'hC0, 16'h0000, 8'h00, 0, 0), 0, 0, 0, 0});
    steps.push_back('{make_op(F_ASL, 8'h81, 16'hFFFF, 8'h00, 0, 0), 0, 0, 0, 0});
    steps.push_back('{make_op(F_ROR, 8'h01, 16'h1234, 8'h00, 1, 0), 0, 0, 0, 0});
    steps.push_back('{make_op(F_BRK, 8'h00, 16'h0000, 8'h00, 0, 0), 0, 0, 0, 0});
    steps.push_back('{make_op(F_JSR, 8'h00, 16'hFFFF, 8'h00, 0, 0), 0, 0, 0, 0});
    steps.push_back('{make_op(F_BNE, 8'h00, 16'h0000, 8'h80, 0, 0), 0, 0, 0, 0});
    steps.push_back('{make_op(F_BEQ, 8'h00, 16'h0000, 8'h7F, 0, 0), 0, 0, 0, 0});
    steps.push_back('{make_op(F_PHP, 8'h00, 16'h0000, 8'h00, 0, 0), 0, 0, 0, 0});
    steps.push_back('{make_op(F_PLP, 8'h00, 16'h0000, 8'h00, 0, 0), 0, 0, 0, 0});
    steps.push_back('{make_op(F_RTI, 8'hFF, 16'h0000, 8'h00, 0, 0), 0, 0, 0, 0});
    steps.push_back('{make_op(F_RTS, 8'h00, 16'h0000, 8'h00, 0, 0), 0, 0, 0, 0});
    steps.push_back('{make_op(F_TXS, 8'h00, 16'h0000, 8'h00, 0, 0), 0, 0, 0, 0});
    steps.push_back('{make_op(F_PHA, 8'h00, 16'h0000, 8'h00, 0, 0), 0, 0, 0, 0});
    steps.push_back('{make_op(6'd63, 8'hFF, 16'hFFFF, 8'hFF, 1, 1), 0, 0, 0, 0});

    cpu_a = 8'h00; cpu_x = 8'h00; cpu_y = 8'h00;
    cpu_sp = SP_RESET; cpu_p = P_RESET; cpu_pc = 16'h0000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < steps.size(); i++) begin
      send_op(steps[i].op);
      // read the typed-in registers straight off the queued final beat
      if (steps[i].check_regs) begin
        it = steps[i].op;
        if (pending_beats[$].new_a !== steps[i].a_exp ||
            pending_beats[$].new_flags !== steps[i].p_exp ||
            pending_beats[$].new_sp !== steps[i].sp_exp) begin
          mismatches++;
          if (mismatches <= 10) $display("directed step %0d predicts wrong registers", i);
        end
      end
    end
    // every operation once, random content
    for (i = 0; i <= F_TYA; i++) begin
      it = rand_op();
      it.func = 6'(i);
      send_op(it);
    end

    // random part across idling phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (n = 0; n < 70; n++) send_op(rand_op());
    end
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    while (pending_beats.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("ran %0d operations, %0d result beats, including a long output hold-off",
             ops_sent, beats_seen);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
